>>> rtl/core/mrr_pkg.sv
// mrr_pkg: shared constants, state encoding and control structs for the
// matrix ring rotation store. No dependencies; used by every rtl/core file.

package mrr_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int DIM_W     = 7;
    localparam int LEN_W     = 9;
    localparam int ROT_W     = 30;
    localparam int DIV_STEPS = 30;
    localparam int CNT_W     = 5;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_ROT_COUNT = 2'd2;

    localparam logic [DIM_W-1:0] ROW_COUNT_RST = 7'd2;
    localparam logic [DIM_W-1:0] COL_COUNT_RST = 7'd2;
    localparam logic [ROT_W-1:0] ROT_COUNT_RST = 30'd0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANGE,
        S_BOUND,
        S_POS,
        S_DIV,
        S_WRAP,
        S_MAP,
        S_READ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_range;
        logic do_bound;
        logic do_pos;
        logic div_step;
        logic do_wrap;
        logic do_map;
        logic do_read;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic is_write;
        logic in_ring;
    } t_dp_stat;

endpackage

>>> rtl/core/matrix_ring_rotation_store.sv
// matrix_ring_rotation_store: a write passes range check and finish; a read outside any ring
// adds map and memory read; a read on a ring adds bounds, position, serial count and wrap.
// The result word becomes valid when the finish state loads it into the output register.
// A ring read reduces the rotation count modulo ring length bit-serially.
// One word in flight; a new word is taken while a finished one waits at the output.
// Synchronous active-low reset clears control and config registers; datapath and cell memory are not cleared.

module matrix_ring_rotation_store #(
    parameter int MAX_ROWS = mrr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrr_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [mrr_pkg::IDX_W-1:0]     i_row,
    input  logic [mrr_pkg::IDX_W-1:0]     i_col,
    input  logic [mrr_pkg::DATA_W-1:0]    i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mrr_pkg::DATA_W-1:0]    o_read_value,
    output logic                          o_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrr_pkg::PADDR_W-1:0]   paddr,
    input  logic [mrr_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;

    logic [mrr_pkg::DIM_W-1:0] r_row_count;
    logic [mrr_pkg::DIM_W-1:0] r_col_count;
    logic [mrr_pkg::ROT_W-1:0] r_rot_count;
    logic [mrr_pkg::DIM_W-1:0] rows_eff;
    logic [mrr_pkg::DIM_W-1:0] cols_eff;
    logic [1:0]                reg_idx;
    logic                      cfg_wr;

    mrr_pkg::t_dp_cmd  cmd;
    mrr_pkg::t_dp_stat stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= mrr_pkg::ROW_COUNT_RST;
            r_col_count <= mrr_pkg::COL_COUNT_RST;
            r_rot_count <= mrr_pkg::ROT_COUNT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mrr_pkg::REG_ROW_COUNT: r_row_count <= pwdata[mrr_pkg::DIM_W-1:0];
                mrr_pkg::REG_COL_COUNT: r_col_count <= pwdata[mrr_pkg::DIM_W-1:0];
                mrr_pkg::REG_ROT_COUNT: r_rot_count <= pwdata[mrr_pkg::ROT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mrr_pkg::REG_ROW_COUNT: prdata = 32'(r_row_count);
            mrr_pkg::REG_COL_COUNT: prdata = 32'(r_col_count);
            mrr_pkg::REG_ROT_COUNT: prdata = 32'(r_rot_count);
            default:                prdata = '0;
        endcase
    end

    // sizes above the array limit saturate
    assign rows_eff = (r_row_count > 7'(ROW_CAP)) ? 7'(ROW_CAP) : r_row_count;
    assign cols_eff = (r_col_count > 7'(COL_CAP)) ? 7'(COL_CAP) : r_col_count;

    mrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mrr_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_rows       (rows_eff),
        .i_cols       (cols_eff),
        .i_rot        (r_rot_count),
        .i_func       (i_func),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .o_read_value (o_read_value),
        .o_error      (o_error)
    );

endmodule

>>> rtl/core/mrr_dp.sv
// mrr_dp: datapath with the cell memory, ring geometry, serial modulo
// and output word register. Depends on mrr_pkg; driven by mrr_ctrl.

module mrr_dp #(
    parameter int MAX_ROWS = mrr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrr_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  mrr_pkg::t_dp_cmd             i_cmd,
    output mrr_pkg::t_dp_stat            o_stat,
    input  logic [mrr_pkg::DIM_W-1:0]    i_rows,
    input  logic [mrr_pkg::DIM_W-1:0]    i_cols,
    input  logic [mrr_pkg::ROT_W-1:0]    i_rot,
    input  logic                         i_func,
    input  logic [mrr_pkg::IDX_W-1:0]    i_row,
    input  logic [mrr_pkg::IDX_W-1:0]    i_col,
    input  logic [mrr_pkg::DATA_W-1:0]   i_value,
    output logic [mrr_pkg::DATA_W-1:0]   o_read_value,
    output logic                         o_error
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int MEM_AW = $clog2(DEPTH);

    logic [mrr_pkg::DATA_W-1:0] mem [DEPTH];

    logic                         r_func;
    logic [mrr_pkg::IDX_W-1:0]    r_row;
    logic [mrr_pkg::IDX_W-1:0]    r_col;
    logic [mrr_pkg::DATA_W-1:0]   r_value;
    logic                         r_err;
    logic                         r_inring;
    logic [mrr_pkg::DIM_W-1:0]    r_k;
    logic [mrr_pkg::DIM_W-1:0]    r_bottom;
    logic [mrr_pkg::DIM_W-1:0]    r_right;
    logic [mrr_pkg::DIM_W-1:0]    r_h;
    logic [mrr_pkg::DIM_W-1:0]    r_w;
    logic [mrr_pkg::LEN_W-1:0]    r_len;
    logic [mrr_pkg::LEN_W-1:0]    r_p;
    logic [mrr_pkg::LEN_W-1:0]    r_rem;
    logic [mrr_pkg::ROT_W-1:0]    r_sh;
    logic [mrr_pkg::LEN_W-1:0]    r_q;
    logic [mrr_pkg::DIM_W-1:0]    r_src_row;
    logic [mrr_pkg::DIM_W-1:0]    r_src_col;
    logic [mrr_pkg::DATA_W-1:0]   r_rdata;
    logic [mrr_pkg::DATA_W-1:0]   r_read_value;
    logic                         r_error;

    logic [mrr_pkg::DIM_W-1:0]    row_x;
    logic [mrr_pkg::DIM_W-1:0]    col_x;
    logic [mrr_pkg::DIM_W-1:0]    d_bot;
    logic [mrr_pkg::DIM_W-1:0]    d_rgt;
    logic [mrr_pkg::DIM_W-1:0]    k_a;
    logic [mrr_pkg::DIM_W-1:0]    k_b;
    logic [mrr_pkg::DIM_W-1:0]    k;
    logic [mrr_pkg::DIM_W-1:0]    half;
    logic                         err;
    logic                         in_ring;
    logic                         wr_en;

    logic [mrr_pkg::DIM_W-1:0]    n_bottom;
    logic [mrr_pkg::DIM_W-1:0]    n_right;
    logic [mrr_pkg::DIM_W-1:0]    n_h;
    logic [mrr_pkg::DIM_W-1:0]    n_w;
    logic [mrr_pkg::LEN_W-1:0]    n_len;
    logic [mrr_pkg::LEN_W-1:0]    n_p;
    logic [mrr_pkg::LEN_W:0]      div_t;
    logic [mrr_pkg::LEN_W-1:0]    n_rem;
    logic [mrr_pkg::LEN_W:0]      sum_q;
    logic [mrr_pkg::LEN_W-1:0]    n_q;
    logic [mrr_pkg::LEN_W-1:0]    n_src_row9;
    logic [mrr_pkg::LEN_W-1:0]    n_src_col9;
    logic [MEM_AW-1:0]            wr_addr;
    logic [MEM_AW-1:0]            rd_addr;

    // range check and ring index
    always_comb begin
        row_x   = {1'b0, r_row};
        col_x   = {1'b0, r_col};
        err     = (row_x >= i_rows) || (col_x >= i_cols);
        d_bot   = i_rows - 7'd1 - row_x;
        d_rgt   = i_cols - 7'd1 - col_x;
        k_a     = (row_x < col_x) ? row_x : col_x;
        k_b     = (d_bot < d_rgt) ? d_bot : d_rgt;
        k       = (k_a < k_b) ? k_a : k_b;
        half    = ((i_rows < i_cols) ? i_rows : i_cols) >> 1;
        in_ring = (k < half);
        wr_en   = i_cmd.do_range && !err && (r_func == mrr_pkg::FUNC_WRITE);
    end

    assign o_stat.err      = err;
    assign o_stat.is_write = (r_func == mrr_pkg::FUNC_WRITE);
    assign o_stat.in_ring  = in_ring;

    // ring bounds and length
    always_comb begin
        n_bottom = i_rows - 7'd1 - r_k;
        n_right  = i_cols - 7'd1 - r_k;
        n_h      = i_rows - {r_k[mrr_pkg::DIM_W-2:0], 1'b0};
        n_w      = i_cols - {r_k[mrr_pkg::DIM_W-2:0], 1'b0};
        n_len    = {(8'(n_h) + 8'(n_w) - 8'd2), 1'b0};
    end

    // position along the ring
    always_comb begin
        if ({1'b0, r_row} == r_k) begin
            n_p = 9'({1'b0, r_col}) - 9'(r_k);
        end else if ({1'b0, r_col} == r_right) begin
            n_p = 9'(r_w) - 9'd1 + 9'({1'b0, r_row}) - 9'(r_k);
        end else if ({1'b0, r_row} == r_bottom) begin
            n_p = 9'(r_w) - 9'd1 + 9'(r_h) - 9'd1 + 9'(r_right) - 9'({1'b0, r_col});
        end else begin
            n_p = {9'(r_w) - 9'd1} + {9'(r_w) - 9'd1} + 9'(r_h) - 9'd1
                + 9'(r_bottom) - 9'({1'b0, r_row});
        end
    end

    // one restoring step of the count modulo ring length, and the wrapped sum of position and remainder
    always_comb begin
        div_t = {r_rem, r_sh[mrr_pkg::ROT_W-1]};
        if (div_t >= {1'b0, r_len}) begin
            n_rem = 9'(div_t - {1'b0, r_len});
        end else begin
            n_rem = 9'(div_t);
        end
        sum_q = {1'b0, r_p} + {1'b0, r_rem};
        if (sum_q >= {1'b0, r_len}) begin
            n_q = 9'(sum_q - {1'b0, r_len});
        end else begin
            n_q = 9'(sum_q);
        end
    end

    // source cell on the ring, or the cell itself when it lies on no ring
    always_comb begin
        if (!r_inring) begin
            n_src_row9 = 9'({1'b0, r_row});
            n_src_col9 = 9'({1'b0, r_col});
        end else if (r_q < 9'(r_w)) begin
            n_src_row9 = 9'(r_k);
            n_src_col9 = 9'(r_k) + r_q;
        end else if (r_q < 9'(r_w) + 9'(r_h) - 9'd1) begin
            n_src_row9 = 9'(r_k) + r_q - 9'(r_w) + 9'd1;
            n_src_col9 = 9'(r_right);
        end else if (r_q < 9'(r_w) + 9'(r_w) + 9'(r_h) - 9'd2) begin
            n_src_row9 = 9'(r_bottom);
            n_src_col9 = 9'(r_right) - (r_q - 9'(r_w) + 9'd1 - 9'(r_h) + 9'd1);
        end else begin
            n_src_row9 = 9'(r_bottom)
                       - (r_q - 9'(r_w) - 9'(r_w) + 9'd2 - 9'(r_h) + 9'd1);
            n_src_col9 = 9'(r_k);
        end
    end

    always_comb begin
        wr_addr = MEM_AW'(int'(r_row) * MAX_COLS + int'(r_col));
        rd_addr = MEM_AW'(int'(r_src_row) * MAX_COLS + int'(r_src_col));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        if (i_cmd.do_range) begin
            r_err    <= err;
            r_k      <= k;
            r_inring <= in_ring;
        end
        if (i_cmd.do_bound) begin
            r_bottom <= n_bottom;
            r_right  <= n_right;
            r_h      <= n_h;
            r_w      <= n_w;
            r_len    <= n_len;
        end
        if (i_cmd.do_pos) begin
            r_p   <= n_p;
            r_rem <= '0;
            r_sh  <= i_rot;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_sh  <= r_sh << 1;
        end
        if (i_cmd.do_wrap) begin
            r_q <= n_q;
        end
        if (i_cmd.do_map) begin
            r_src_row <= n_src_row9[mrr_pkg::DIM_W-1:0];
            r_src_col <= n_src_col9[mrr_pkg::DIM_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_read_value <= (!r_err && r_func == mrr_pkg::FUNC_READ) ? r_rdata : '0;
            r_error      <= r_err;
        end
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_cmd.do_read) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_read_value = r_read_value;
    assign o_error      = r_error;

endmodule

>>> rtl/core/mrr_ctrl.sv
// mrr_ctrl: sequencer for one word at a time and the output valid flag.
// Depends on mrr_pkg; commands mrr_dp.

module mrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mrr_pkg::t_dp_cmd   o_cmd,
    input  mrr_pkg::t_dp_stat  i_stat
);

    mrr_pkg::t_state           r_state;
    mrr_pkg::t_state           n_state;
    logic [mrr_pkg::CNT_W-1:0] r_cnt;
    logic [mrr_pkg::CNT_W-1:0] n_cnt;
    logic                      r_ovalid;
    logic                      n_ovalid;
    logic                      out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mrr_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        out_free = !r_ovalid || !i_out_stall;
        n_ovalid = (r_ovalid && i_out_stall);
        case (r_state)
            mrr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = mrr_pkg::S_RANGE;
                end
            end
            mrr_pkg::S_RANGE: begin
                o_cmd.do_range = 1'b1;
                if (i_stat.err || i_stat.is_write) begin
                    n_state = mrr_pkg::S_FIN;
                end else if (i_stat.in_ring) begin
                    n_state = mrr_pkg::S_BOUND;
                end else begin
                    n_state = mrr_pkg::S_MAP;
                end
            end
            mrr_pkg::S_BOUND: begin
                o_cmd.do_bound = 1'b1;
                n_state        = mrr_pkg::S_POS;
            end
            mrr_pkg::S_POS: begin
                o_cmd.do_pos = 1'b1;
                n_cnt        = '0;
                n_state      = mrr_pkg::S_DIV;
            end
            mrr_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == mrr_pkg::CNT_W'(mrr_pkg::DIV_STEPS - 1)) begin
                    n_state = mrr_pkg::S_WRAP;
                end
            end
            mrr_pkg::S_WRAP: begin
                o_cmd.do_wrap = 1'b1;
                n_state       = mrr_pkg::S_MAP;
            end
            mrr_pkg::S_MAP: begin
                o_cmd.do_map = 1'b1;
                n_state      = mrr_pkg::S_READ;
            end
            mrr_pkg::S_READ: begin
                o_cmd.do_read = 1'b1;
                n_state       = mrr_pkg::S_FIN;
            end
            mrr_pkg::S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = mrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != mrr_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

>>> rtl/core/mrr_chk.sv
// mrr_chk: port-level checks on the matrix ring rotation store.
// Depends on matrix_ring_rotation_store; attached by the bind below.

module mrr_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [mrr_pkg::DATA_W-1:0] o_read_value,
    input logic                       o_error
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_read_value) && $stable(o_error))
        else $error("stalled output word changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_read_value == '0)
        else $error("flagged word carries a value");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or busy after reset");

endmodule

bind matrix_ring_rotation_store mrr_chk u_mrr_chk (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: directed table then random store/read words for matrix_ring_rotation_store,
// each result checked against a fixed table value or a ring rotation predictor kept in the bench.
// Depends on mrr_pkg and the rtl top level only.

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 48;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [mrr_pkg::DATA_W-1:0] read_value;
        logic                       error;
    } t_cell_result;

    typedef enum logic [1:0] {
        STEP_GEOMETRY,
        STEP_PREDICTED,
        STEP_FIXED
    } t_step_kind;

    typedef struct {
        t_step_kind                 kind;
        logic                       func;
        logic [mrr_pkg::IDX_W-1:0]  row;
        logic [mrr_pkg::IDX_W-1:0]  col;
        logic [mrr_pkg::DATA_W-1:0] value;
        t_cell_result               want;
        logic [mrr_pkg::DIM_W-1:0]  geom_rows;
        logic [mrr_pkg::DIM_W-1:0]  geom_cols;
        logic [mrr_pkg::ROT_W-1:0]  geom_rot;
    } t_plan_step;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_func = mrr_pkg::FUNC_WRITE;
    logic [mrr_pkg::IDX_W-1:0]     i_row = '0;
    logic [mrr_pkg::IDX_W-1:0]     i_col = '0;
    logic [mrr_pkg::DATA_W-1:0]    i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [mrr_pkg::DATA_W-1:0]    o_read_value;
    logic                          o_error;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [mrr_pkg::PADDR_W-1:0]   paddr = '0;
    logic [mrr_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [mrr_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // bench copy of the cell memory and the registers
    logic [mrr_pkg::DATA_W-1:0] cell_image [mrr_pkg::MAX_ROWS_DEF][mrr_pkg::MAX_COLS_DEF];
    bit                         cell_known [mrr_pkg::MAX_ROWS_DEF][mrr_pkg::MAX_COLS_DEF];
    logic [mrr_pkg::ROT_W-1:0]  rot_setting = mrr_pkg::ROT_COUNT_RST;
    int unsigned                rows_used = mrr_pkg::ROW_COUNT_RST;
    int unsigned                cols_used = mrr_pkg::COL_COUNT_RST;

    t_cell_result expected_cells [$];
    t_plan_step   stimulus_plan [$];
    int           send_idle_pct = 16;
    int           recv_stall_pct = 62;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    matrix_ring_rotation_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_error      (o_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("matrix_ring_rotation_store: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [mrr_pkg::DATA_W-1:0] got,
                                   input logic [mrr_pkg::DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: bad %s, got %h, wanted %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // walk the ring from its top-left corner and step on by the rotation count
    function automatic void ring_source(input int unsigned r, input int unsigned c,
                                        output int unsigned src_r, output int unsigned src_c);
        int unsigned k, top, left, bottom, right, h, w, len, p, q;
        src_r = r;
        src_c = c;
        k = (r < c) ? r : c;
        if (rows_used - 1 - r < k) k = rows_used - 1 - r;
        if (cols_used - 1 - c < k) k = cols_used - 1 - c;
        if (k >= ((rows_used < cols_used) ? rows_used : cols_used) / 2) return;
        top    = k;
        left   = k;
        bottom = rows_used - 1 - k;
        right  = cols_used - 1 - k;
        h      = rows_used - 2 * k;
        w      = cols_used - 2 * k;
        len    = 2 * (h + w - 2);
        if (r == top)
            p = c - left;
        else if (c == right)
            p = (w - 1) + (r - top);
        else if (r == bottom)
            p = (w - 1) + (h - 1) + (right - c);
        else
            p = 2 * (w - 1) + (h - 1) + (bottom - r);
        q = (p + rot_setting % len) % len;
        if (q < w) begin
            src_r = top;
            src_c = left + q;
        end else if (q < w + h - 1) begin
            src_r = top + (q - (w - 1));
            src_c = right;
        end else if (q < 2 * w + h - 2) begin
            src_r = bottom;
            src_c = right - (q - (w - 1) - (h - 1));
        end else begin
            src_r = bottom - (q - 2 * (w - 1) - (h - 1));
            src_c = left;
        end
    endfunction

    function automatic t_cell_result apply_word(input logic f,
                                                input logic [mrr_pkg::IDX_W-1:0] r,
                                                input logic [mrr_pkg::IDX_W-1:0] c,
                                                input logic [mrr_pkg::DATA_W-1:0] v);
        t_cell_result res;
        int unsigned  src_r, src_c;
        res = '0;
        if (r >= rows_used || c >= cols_used) begin
            res.error = 1'b1;
        end else if (f == mrr_pkg::FUNC_WRITE) begin
            cell_image[r][c] = v;
            cell_known[r][c] = 1'b1;
        end else begin
            ring_source(r, c, src_r, src_c);
            res.read_value = cell_image[src_r][src_c];
        end
        return res;
    endfunction

    task automatic set_geometry(input logic [mrr_pkg::DIM_W-1:0] r,
                                input logic [mrr_pkg::DIM_W-1:0] c,
                                input logic [mrr_pkg::ROT_W-1:0] rot);
        logic [1:0]                  reg_idx [3];
        logic [mrr_pkg::PDATA_W-1:0] reg_val [3];
        reg_idx = '{mrr_pkg::REG_ROW_COUNT, mrr_pkg::REG_COL_COUNT, mrr_pkg::REG_ROT_COUNT};
        reg_val = '{mrr_pkg::PDATA_W'(r), mrr_pkg::PDATA_W'(c), mrr_pkg::PDATA_W'(rot)};
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx[i], 2'b00};
            pwdata  <= reg_val[i];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rot_setting = rot;
        rows_used = (r > mrr_pkg::MAX_ROWS_DEF) ? mrr_pkg::MAX_ROWS_DEF : r;
        cols_used = (c > mrr_pkg::MAX_COLS_DEF) ? mrr_pkg::MAX_COLS_DEF : c;
    endtask

    task automatic send_word(input logic f, input logic [mrr_pkg::IDX_W-1:0] r,
                             input logic [mrr_pkg::IDX_W-1:0] c,
                             input logic [mrr_pkg::DATA_W-1:0] v,
                             input bit fixed, input t_cell_result fixed_res);
        t_cell_result res;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_row      <= r;
        i_col      <= c;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        res = apply_word(f, r, c, v);
        expected_cells.insert(expected_cells.size(), fixed ? fixed_res : res);
    endtask

    // a read never lands on a cell that was never stored: store its source first
    task automatic issue_word(input logic f, input logic [mrr_pkg::IDX_W-1:0] r,
                              input logic [mrr_pkg::IDX_W-1:0] c,
                              input logic [mrr_pkg::DATA_W-1:0] v,
                              input bit fixed, input t_cell_result fixed_res);
        int unsigned src_r, src_c;
        if (f == mrr_pkg::FUNC_READ && r < rows_used && c < cols_used) begin
            ring_source(r, c, src_r, src_c);
            if (!cell_known[src_r][src_c])
                send_word(mrr_pkg::FUNC_WRITE, mrr_pkg::IDX_W'(src_r), mrr_pkg::IDX_W'(src_c),
                          $urandom(), 1'b0, '0);
        end
        send_word(f, r, c, v, fixed, fixed_res);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
    endtask

    task automatic plan_geometry(input logic [mrr_pkg::DIM_W-1:0] r,
                                 input logic [mrr_pkg::DIM_W-1:0] c,
                                 input logic [mrr_pkg::ROT_W-1:0] rot);
        t_plan_step s;
        s = '{kind: STEP_GEOMETRY, func: mrr_pkg::FUNC_WRITE, row: '0, col: '0, value: '0,
              want: '0, geom_rows: r, geom_cols: c, geom_rot: rot};
        stimulus_plan.insert(stimulus_plan.size(), s);
    endtask

    task automatic plan_word(input t_step_kind k, input logic f,
                             input logic [mrr_pkg::IDX_W-1:0] r,
                             input logic [mrr_pkg::IDX_W-1:0] c,
                             input logic [mrr_pkg::DATA_W-1:0] v,
                             input logic [mrr_pkg::DATA_W-1:0] want_value,
                             input logic want_error);
        t_plan_step s;
        s = '{kind: k, func: f, row: r, col: c, value: v,
              want: '{read_value: want_value, error: want_error},
              geom_rows: '0, geom_cols: '0, geom_rot: '0};
        stimulus_plan.insert(stimulus_plan.size(), s);
    endtask

    function automatic logic [mrr_pkg::DIM_W-1:0] pick_dim();
        logic [mrr_pkg::DIM_W-1:0] odd_sizes [6];
        odd_sizes = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
        case ($urandom_range(9))
            0: return odd_sizes[$urandom_range(5)];
            1, 2: return mrr_pkg::DIM_W'($urandom_range(64, 2));
            default: return mrr_pkg::DIM_W'($urandom_range(9, 2));
        endcase
    endfunction

    function automatic logic [mrr_pkg::ROT_W-1:0] pick_rotation();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return mrr_pkg::ROT_W'($urandom());
            default: return mrr_pkg::ROT_W'($urandom_range(600));
        endcase
    endfunction

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch("unexpected word", o_read_value, '0);
                end else begin
                    want = expected_cells.pop_front();
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", o_read_value, want.read_value);
                    if (o_error !== want.error)
                        report_mismatch("error", mrr_pkg::DATA_W'(o_error),
                                        mrr_pkg::DATA_W'(want.error));
                end
            end
            i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        logic                      f;
        logic [mrr_pkg::IDX_W-1:0] r, c;

        // after reset: 2 x 2, no rotation
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd0, 6'd1, 32'h8000_0000, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd1, 6'd0, 32'h0000_0001, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd1, 6'd1, 32'hFFFF_FFFF, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd1, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b0);
        // out of range store and reads
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd2, 6'd0, 32'h1234_5678, 32'h0, 1'b1);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd0, 6'd2, 32'h0, 32'h0, 1'b1);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd63, 6'd63, 32'h0, 32'h0, 1'b1);
        plan_geometry(7'd2, 7'd2, 30'd1);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd1, 6'd0, 32'h0, 32'h0, 1'b0);
        plan_geometry(7'd2, 7'd2, 30'h3FFF_FFFF);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd0, 6'd1, 32'h0, 32'h0, 1'b0);
        // single row: no rings at all
        plan_geometry(7'd1, 7'd64, 30'd0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd0, 6'd63, 32'hA5A5_A5A5, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd0, 6'd63, 32'h0, 32'hA5A5_A5A5, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd1, 6'd0, 32'h0, 32'h0, 1'b1);
        // zero rows: everything out of range
        plan_geometry(7'd0, 7'd64, 30'd0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0, 32'h0, 1'b1);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd0, 6'd0, 32'h1, 32'h0, 1'b1);
        // oversized counts saturate to the full matrix
        plan_geometry(7'd127, 7'd127, 30'h3FFF_FFFF);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd63, 6'd63, 32'hDEAD_BEEF, 32'h0, 1'b0);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd63, 6'd63, 32'h0, 32'h0, 1'b0);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd31, 6'd31, 32'h0, 32'h0, 1'b0);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd32, 6'd0, 32'h0, 32'h0, 1'b0);
        // odd width: middle column lies on no ring
        plan_geometry(7'd64, 7'd3, 30'd5);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_WRITE, 6'd10, 6'd1, 32'h55AA_55AA, 32'h0, 1'b0);
        plan_word(STEP_FIXED, mrr_pkg::FUNC_READ, 6'd10, 6'd1, 32'h0, 32'h55AA_55AA, 1'b0);
        plan_word(STEP_PREDICTED, mrr_pkg::FUNC_READ, 6'd5, 6'd0, 32'h0, 32'h0, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stimulus_plan[i]) begin
            if (stimulus_plan[i].kind == STEP_GEOMETRY) begin
                drain_results();
                set_geometry(stimulus_plan[i].geom_rows, stimulus_plan[i].geom_cols,
                             stimulus_plan[i].geom_rot);
            end else begin
                issue_word(stimulus_plan[i].func, stimulus_plan[i].row,
                           stimulus_plan[i].col, stimulus_plan[i].value,
                           stimulus_plan[i].kind == STEP_FIXED, stimulus_plan[i].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 16 : ((phase == 1) ? 62 : 0);
            recv_stall_pct = (phase == 0) ? 62 : ((phase == 1) ? 16 : 0);
            for (int blk = 0; blk < 6; blk++) begin
                drain_results();
                set_geometry(pick_dim(), pick_dim(), pick_rotation());
                repeat (56) begin
                    f = ($urandom_range(99) < 55) ? mrr_pkg::FUNC_READ : mrr_pkg::FUNC_WRITE;
                    if (rows_used == 0 || $urandom_range(99) < 15)
                        r = mrr_pkg::IDX_W'($urandom_range(63));
                    else
                        r = mrr_pkg::IDX_W'($urandom_range(rows_used - 1));
                    if (cols_used == 0 || $urandom_range(99) < 15)
                        c = mrr_pkg::IDX_W'($urandom_range(63));
                    else
                        c = mrr_pkg::IDX_W'($urandom_range(cols_used - 1));
                    issue_word(f, r, c, $urandom(), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("matrix_ring_rotation_store: match");
        else
            $display("matrix_ring_rotation_store: mismatch");
        $finish;
    end

endmodule
